### src/ipid_pkg.sv
`timescale 1ns / 1ps

package ipid_pkg;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SET  = 2'd1;
   localparam logic [1:0] FUNC_STOP = 2'd2;

   localparam logic signed [1:0] DIR_ZERO = 2'sb00;
   localparam logic signed [1:0] DIR_POS  = 2'sb01;
   localparam logic signed [1:0] DIR_NEG  = 2'sb11;

   localparam logic [14:0] DUTY_MAX     = 15'd31129;
   localparam logic [14:0] DUTY_MIN_MAG = 15'd4915;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_TICK,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      WIN_BOTH,
      WIN_POS,
      WIN_NEG
   } win_type;

   typedef struct packed {
      op_type  op;
      win_type win;
   } ctrl_type;

   typedef struct packed {
      ctrl_type            ctrl;
      logic signed [16:0]  err;
      logic signed [31:0]  sum;
      logic signed [17:0]  diff;
   } err_type;

endpackage

### src/ipid_error_stage.sv
`timescale 1ns / 1ps

module ipid_error_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [1:0]          func,
   input  logic signed [15:0]  measured_speed,
   input  logic signed [15:0]  target_speed,
   output ipid_pkg::err_type   result
);
   import ipid_pkg::*;

   logic signed [15:0] setpoint_ff, setpoint_in;
   logic signed [1:0]  direction_ff, direction_in;
   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [16:0] previous_error_ff, previous_error_in;

   logic signed [16:0] err;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic signed [1:0]  new_sign;

   assign err      = 17'(setpoint_ff) - 17'(measured_speed);
   assign sum_wide = 33'(error_sum_ff) + 33'(err);

   always_comb begin
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sum_sat = sum_wide[31:0];
      end

      if (target_speed > 16'sd0) begin
         new_sign = DIR_POS;
      end else if (target_speed < 16'sd0) begin
         new_sign = DIR_NEG;
      end else begin
         new_sign = DIR_ZERO;
      end

      setpoint_in       = setpoint_ff;
      direction_in      = direction_ff;
      error_sum_in      = error_sum_ff;
      previous_error_in = previous_error_ff;
      result.ctrl.op    = OP_NONE;

      case (func)
         FUNC_TICK: begin
            if (setpoint_ff != 16'sd0 && err != 17'sd1 && err != -17'sd1) begin
               error_sum_in = sum_sat;
            end
            previous_error_in = err;
            result.ctrl.op    = OP_TICK;
         end
         FUNC_SET: begin
            if (setpoint_ff != target_speed) begin
               error_sum_in = 32'sd0;
               if ((direction_ff == DIR_POS && new_sign == DIR_NEG) ||
                   (direction_ff == DIR_NEG && new_sign == DIR_POS)) begin
                  result.ctrl.op = OP_CLEAR;
               end
            end
            setpoint_in  = target_speed;
            direction_in = new_sign;
         end
         FUNC_STOP: begin
            setpoint_in    = 16'sd0;
            error_sum_in   = 32'sd0;
            result.ctrl.op = OP_CLEAR;
         end
         default: begin
            result.ctrl.op = OP_NONE;
         end
      endcase

      if (setpoint_ff == 16'sd0) begin
         result.ctrl.win = WIN_BOTH;
      end else if (setpoint_ff > 16'sd0) begin
         result.ctrl.win = WIN_POS;
      end else begin
         result.ctrl.win = WIN_NEG;
      end

      result.err  = err;
      result.sum  = error_sum_in;
      result.diff = 18'(err) - 18'(previous_error_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= '0;
         direction_ff      <= DIR_ZERO;
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else if (advance) begin
         setpoint_ff       <= setpoint_in;
         direction_ff      <= direction_in;
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= previous_error_in;
      end
   end

endmodule

### src/incremental_pid_motor_speed.sv
`timescale 1ns / 1ps

// Incremental PID speed controller. One transaction is taken per clock cycle unless req_stall
// is high; a control tick gives its duty result through a pipeline of input, error, gain
// multiplication, term sum and duty increment stages, with the held duty updated in the
// last stage. Set-speed and stop transactions give no result but pass through the same stages
// so that their effect on the held duty keeps transaction order. The three gain multipliers
// each take operands of at most 32 bits and sit in their own stage. Gains must be written by
// the user on the csr_ port only while the block is idle; the block itself does not enforce this.
module incremental_pid_motor_speed (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic signed [15:0]  req_measured_speed,
   input  logic signed [15:0]  req_target_speed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_duty,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import ipid_pkg::*;

   localparam logic [1:0]  CSR_GAIN_P = 2'd0;
   localparam logic [1:0]  CSR_GAIN_I = 2'd1;
   localparam logic [1:0]  CSR_GAIN_D = 2'd2;
   localparam logic [63:0] TERM_CAP   = 64'h1000_0000_0000_0000;

   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff;

   // Stage valids and handshake.
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, rsp_valid_ff;
   logic a_v_in, b_v_in, c_v_in, d_v_in, e_v_in, rsp_valid_in;
   logic accept, out_free;
   logic move_a, move_b, move_c, move_d, move_e;
   logic ready_a, ready_b, ready_c, ready_d, ready_e;

   // Input stage.
   logic [1:0]         a_func_ff;
   logic signed [15:0] a_meas_ff, a_target_ff;

   // Error stage.
   err_type err_res;
   err_type b_err_ff;

   // Multiply stage.
   ctrl_type    c_ctrl_ff;
   logic [15:0] abs_err;
   logic [31:0] abs_sum;
   logic [16:0] abs_diff;
   logic [47:0] prod_p_in, prod_p_ff;
   logic [63:0] prod_i_in, prod_i_ff;
   logic [48:0] prod_d_in, prod_d_ff;
   logic        c_neg_p_ff, c_neg_i_ff, c_neg_d_ff;

   // Sum stage.
   ctrl_type    d_ctrl_ff;
   logic [63:0] term_p, term_i, term_d, cap_i;
   logic [63:0] d_u_in, d_u_ff;

   // Duty increment stage.
   ctrl_type           e_ctrl_ff;
   logic [63:0]        u_mag;
   logic [54:0]        u_q15;
   logic [14:0]        mv_mag;
   logic signed [15:0] e_mv_in, e_mv_ff;

   // Held duty.
   logic signed [15:0] held_duty_ff, held_duty_in;
   logic signed [16:0] duty_sum, duty_lo, duty_hi, duty_clamped;
   logic signed [15:0] rsp_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 32'd83886;
         gain_i_ff <= 32'd3355;
         gain_d_ff <= 32'd8388;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_P: gain_p_ff <= csr_data;
            CSR_GAIN_I: gain_i_ff <= csr_data;
            CSR_GAIN_D: gain_d_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign move_e   = e_v_ff && (out_free || e_ctrl_ff.op != OP_TICK);
   assign ready_e  = !e_v_ff || move_e;
   assign move_d   = d_v_ff && ready_e;
   assign ready_d  = !d_v_ff || ready_e;
   assign move_c   = c_v_ff && ready_d;
   assign ready_c  = !c_v_ff || ready_d;
   assign move_b   = b_v_ff && ready_c;
   assign ready_b  = !b_v_ff || ready_c;
   assign move_a   = a_v_ff && ready_b;
   assign ready_a  = !a_v_ff || ready_b;
   assign req_stall = !ready_a;
   assign accept    = req_valid && ready_a;

   assign a_v_in       = accept || (a_v_ff && !move_a);
   assign b_v_in       = move_a || (b_v_ff && !move_b);
   assign c_v_in       = move_b || (c_v_ff && !move_c);
   assign d_v_in       = move_c || (d_v_ff && !move_d);
   assign e_v_in       = move_d || (e_v_ff && !move_e);
   assign rsp_valid_in = (move_e && e_ctrl_ff.op == OP_TICK) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         e_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         c_v_ff       <= c_v_in;
         d_v_ff       <= d_v_in;
         e_v_ff       <= e_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff   <= req_func;
         a_meas_ff   <= req_measured_speed;
         a_target_ff <= req_target_speed;
      end
   end

   ipid_error_stage u_error_stage (
      .clock          (clock),
      .reset          (reset),
      .advance        (move_a),
      .func           (a_func_ff),
      .measured_speed (a_meas_ff),
      .target_speed   (a_target_ff),
      .result         (err_res)
   );

   always_ff @(posedge clock) begin
      if (move_a) begin
         b_err_ff <= err_res;
      end
   end

   always_comb begin
      abs_err   = b_err_ff.err[16] ? 16'(-b_err_ff.err) : 16'(b_err_ff.err);
      abs_sum   = b_err_ff.sum[31] ? 32'(-b_err_ff.sum) : 32'(b_err_ff.sum);
      abs_diff  = b_err_ff.diff[17] ? 17'(-b_err_ff.diff) : 17'(b_err_ff.diff);
      prod_p_in = 48'(abs_err) * 48'(gain_p_ff);
      prod_i_in = 64'(abs_sum) * 64'(gain_i_ff);
      prod_d_in = 49'(abs_diff) * 49'(gain_d_ff);
   end

   always_ff @(posedge clock) begin
      if (move_b) begin
         c_ctrl_ff  <= b_err_ff.ctrl;
         prod_p_ff  <= prod_p_in;
         prod_i_ff  <= prod_i_in;
         prod_d_ff  <= prod_d_in;
         c_neg_p_ff <= b_err_ff.err[16];
         c_neg_i_ff <= b_err_ff.sum[31];
         c_neg_d_ff <= b_err_ff.diff[17];
      end
   end

   // The proportional and derivative products stay below 2^49, so only the integral term
   // can reach the cap.
   always_comb begin
      cap_i  = (prod_i_ff > TERM_CAP) ? TERM_CAP : prod_i_ff;
      term_p = c_neg_p_ff ? -64'(prod_p_ff) : 64'(prod_p_ff);
      term_i = c_neg_i_ff ? -cap_i : cap_i;
      term_d = c_neg_d_ff ? -64'(prod_d_ff) : 64'(prod_d_ff);
      d_u_in = term_p + term_i + term_d;
   end

   always_ff @(posedge clock) begin
      if (move_c) begin
         d_ctrl_ff <= c_ctrl_ff;
         d_u_ff    <= d_u_in;
      end
   end

   always_comb begin
      u_mag  = d_u_ff[63] ? -d_u_ff : d_u_ff;
      u_q15  = u_mag[63:9];
      mv_mag = (u_q15 > 55'(DUTY_MAX)) ? DUTY_MAX : u_q15[14:0];
      e_mv_in = d_u_ff[63] ? -16'(mv_mag) : 16'(mv_mag);
   end

   always_ff @(posedge clock) begin
      if (move_d) begin
         e_ctrl_ff <= d_ctrl_ff;
         e_mv_ff   <= e_mv_in;
      end
   end

   always_comb begin
      duty_sum = 17'(held_duty_ff) + 17'(e_mv_ff);
      case (e_ctrl_ff.win)
         WIN_POS: begin
            duty_lo = 17'(DUTY_MIN_MAG);
            duty_hi = 17'(DUTY_MAX);
         end
         WIN_NEG: begin
            duty_lo = -17'(DUTY_MAX);
            duty_hi = -17'(DUTY_MIN_MAG);
         end
         default: begin
            duty_lo = -17'(DUTY_MAX);
            duty_hi = 17'(DUTY_MAX);
         end
      endcase
      if (duty_sum < duty_lo) begin
         duty_clamped = duty_lo;
      end else if (duty_sum > duty_hi) begin
         duty_clamped = duty_hi;
      end else begin
         duty_clamped = duty_sum;
      end
      case (e_ctrl_ff.op)
         OP_TICK:  held_duty_in = duty_clamped[15:0];
         OP_CLEAR: held_duty_in = 16'sd0;
         default:  held_duty_in = held_duty_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_duty_ff <= '0;
      end else if (move_e) begin
         held_duty_ff <= held_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move_e && e_ctrl_ff.op == OP_TICK) begin
         rsp_duty_ff <= held_duty_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty  = rsp_duty_ff;

   // The input stage can only hold off a new transaction while it is itself occupied.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> a_v_ff)
      else $error("input stalled with an empty input stage");

   // A result appears only after a tick transaction has left the last stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(move_e && e_ctrl_ff.op == OP_TICK))
      else $error("result raised without a tick transaction");

   // A tick with a positive setpoint never gives a duty below the minimum magnitude.
   assert property (@(posedge clock) disable iff (reset)
      (move_e && e_ctrl_ff.op == OP_TICK && e_ctrl_ff.win == WIN_POS)
      |=> (rsp_duty_ff >= 16'(DUTY_MIN_MAG)))
      else $error("duty below window for a positive setpoint");

   // A stop or a reversal leaves the held duty at zero.
   assert property (@(posedge clock) disable iff (reset)
      (move_e && e_ctrl_ff.op == OP_CLEAR) |=> (held_duty_ff == 16'sd0))
      else $error("held duty not cleared");

endmodule
